/* hdl/tbaq_pkg.sv */
`default_nettype none

package tbaq_pkg;

   // Default values of the top-level parameters.
   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int STAT_LIMIT_DEFAULT   = 65536;

   // Threshold register, Q4.12, unsigned.
   localparam int                THRESH_WIDTH = 16;
   localparam logic [15:0]       THRESH_RESET = 16'd4096;

   // The sum of squares saturates at its all-ones value.
   localparam int SUM_WIDTH  = 47;
   // Root of a value of up to SUM_WIDTH bits, taken two radicand bits a step.
   localparam int ROOT_WIDTH = (SUM_WIDTH + 1) / 2;

   // Depth of the queue between the classifier and the packer.
   localparam int QUEUE_DEPTH = 4;

   // Two-bit output codes.
   localparam logic [1:0] CODE_BELOW  = 2'd0;
   localparam logic [1:0] CODE_NONPOS = 2'd1;
   localparam logic [1:0] CODE_POS    = 2'd2;
   localparam logic [1:0] CODE_ABOVE  = 2'd3;

   // Slot of the last code in a byte.
   localparam logic [1:0] LAST_SLOT = 2'd3;

   typedef struct packed {
      logic [1:0] code;
      logic       eop;
   } tbaq_entry_type;

   typedef enum logic [1:0] {
      FE_RUN,
      FE_SETTLE,
      FE_LAUNCH,
      FE_WAIT
   } tbaq_front_state_type;

   typedef enum logic [1:0] {
      RMS_IDLE,
      RMS_DIV,
      RMS_SQRT,
      RMS_DONE
   } tbaq_rms_state_type;

endpackage

`default_nettype wire

/* hdl/tbaq_queue.sv */
`default_nettype none

module tbaq_queue #(
   parameter int DEPTH = tbaq_pkg::QUEUE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire tbaq_pkg::tbaq_entry_type push_data,
   input  wire logic                     pop,
   output      tbaq_pkg::tbaq_entry_type head,
   output      logic                     empty,
   output      logic                     full
);
   import tbaq_pkg::*;

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   tbaq_entry_type         entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_WIDTH'(DEPTH));
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* hdl/tbaq_rms.sv */
`default_nettype none

// Computes floor(sqrt(sum / count)) with a restoring divider, one quotient
// bit per cycle, followed by a digit-by-digit square root, one root bit per
// cycle.
module tbaq_rms #(
   parameter int STAT_LIMIT = tbaq_pkg::STAT_LIMIT_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [tbaq_pkg::SUM_WIDTH-1:0]       sum,
   input  wire logic [$clog2(STAT_LIMIT + 1)-1:0]    count,
   output      logic                                 done,
   output      logic [tbaq_pkg::THRESH_WIDTH-1:0]    threshold
);
   import tbaq_pkg::*;

   localparam int CNT_WIDTH  = $clog2(STAT_LIMIT + 1);
   localparam int RAD_WIDTH  = 2 * ROOT_WIDTH;
   localparam int SREM_WIDTH = ROOT_WIDTH + 1;
   localparam int STEP_WIDTH = $clog2(SUM_WIDTH);

   tbaq_rms_state_type       state_ff, state_in;
   logic [STEP_WIDTH-1:0]    step_ff, step_in;
   logic [SUM_WIDTH-1:0]     dividend_ff, dividend_in;
   logic [CNT_WIDTH-1:0]     divisor_ff, divisor_in;
   logic [CNT_WIDTH-1:0]     rem_ff, rem_in;
   logic [RAD_WIDTH-1:0]     rad_ff, rad_in;
   logic [ROOT_WIDTH-1:0]    root_ff, root_in;
   logic [SREM_WIDTH-1:0]    srem_ff, srem_in;
   logic [CNT_WIDTH:0]       rem_shift;
   logic [SREM_WIDTH+1:0]    srem_shift;
   logic [SREM_WIDTH+1:0]    trial;
   logic                     div_fits;
   logic                     sqrt_fits;
   logic                     last_step;

   assign last_step  = (step_ff == '0);
   assign rem_shift  = {rem_ff, dividend_ff[SUM_WIDTH-1]};
   assign div_fits   = (rem_shift >= {1'b0, divisor_ff});
   assign srem_shift = {srem_ff, rad_ff[RAD_WIDTH-1 -: 2]};
   assign trial      = {1'b0, root_ff, 2'b01};
   assign sqrt_fits  = (srem_shift >= trial);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         RMS_IDLE: begin
            if (start) begin
               state_in = RMS_DIV;
            end
         end
         RMS_DIV: begin
            if (last_step) begin
               state_in = RMS_SQRT;
            end
         end
         RMS_SQRT: begin
            if (last_step) begin
               state_in = RMS_DONE;
            end
         end
         RMS_DONE: state_in = RMS_IDLE;
         default:  state_in = RMS_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      done      = (state_ff == RMS_DONE);
      threshold = (|root_ff[ROOT_WIDTH-1:THRESH_WIDTH]) ? '1 : root_ff[THRESH_WIDTH-1:0];
   end

   // Datapath.
   always_comb begin
      step_in     = step_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      rad_in      = rad_ff;
      root_in     = root_ff;
      srem_in     = srem_ff;
      case (state_ff)
         RMS_IDLE: begin
            if (start) begin
               dividend_in = sum;
               divisor_in  = count;
               rem_in      = '0;
               step_in     = STEP_WIDTH'(SUM_WIDTH - 1);
            end
         end
         RMS_DIV: begin
            // The quotient bits shift in behind the dividend bits.
            if (div_fits) begin
               rem_in = CNT_WIDTH'(rem_shift - {1'b0, divisor_ff});
            end else begin
               rem_in = rem_shift[CNT_WIDTH-1:0];
            end
            dividend_in = {dividend_ff[SUM_WIDTH-2:0], div_fits};
            step_in     = step_ff - 1'b1;
            if (last_step) begin
               rad_in  = RAD_WIDTH'({dividend_ff[SUM_WIDTH-2:0], div_fits});
               root_in = '0;
               srem_in = '0;
               step_in = STEP_WIDTH'(ROOT_WIDTH - 1);
            end
         end
         RMS_SQRT: begin
            if (sqrt_fits) begin
               srem_in = SREM_WIDTH'(srem_shift - trial);
            end else begin
               srem_in = srem_shift[SREM_WIDTH-1:0];
            end
            root_in = {root_ff[ROOT_WIDTH-2:0], sqrt_fits};
            rad_in  = {rad_ff[RAD_WIDTH-3:0], 2'b00};
            step_in = step_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RMS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      rad_ff      <= rad_in;
      root_ff     <= root_in;
      srem_ff     <= srem_in;
   end

endmodule

`default_nettype wire

/* hdl/tbaq_front.sv */
`default_nettype none

module tbaq_front #(
   parameter int SAMPLE_WIDTH = tbaq_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int STAT_LIMIT   = tbaq_pkg::STAT_LIMIT_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0]       req_sample_value,
   input  wire logic                                 req_end_of_packet,
   input  wire logic                                 csr_write_enable,
   input  wire logic [tbaq_pkg::THRESH_WIDTH-1:0]    csr_write_data,
   input  wire logic                                 queue_full,
   output      logic                                 queue_push,
   output      tbaq_pkg::tbaq_entry_type             queue_data,
   output      logic                                 rms_start,
   output      logic [tbaq_pkg::SUM_WIDTH-1:0]       rms_sum,
   output      logic [$clog2(STAT_LIMIT + 1)-1:0]    rms_count,
   input  wire logic                                 rms_done,
   input  wire logic [tbaq_pkg::THRESH_WIDTH-1:0]    rms_threshold
);
   import tbaq_pkg::*;

   localparam int CNT_WIDTH = $clog2(STAT_LIMIT + 1);
   localparam int SQ_WIDTH  = 2 * SAMPLE_WIDTH - 1;
   localparam int CMP_WIDTH = ((SAMPLE_WIDTH > THRESH_WIDTH) ? SAMPLE_WIDTH : THRESH_WIDTH) + 2;

   tbaq_front_state_type        state_ff, state_in;
   logic [THRESH_WIDTH-1:0]     threshold_ff, threshold_in;
   logic [CNT_WIDTH-1:0]        count_ff, count_in;
   logic [SUM_WIDTH-1:0]        sum_ff, sum_in;
   logic [SQ_WIDTH-1:0]         sq_ff;
   logic                        sq_valid_ff, sq_valid_in;
   logic                        accept;
   logic                        stat_open;
   logic signed [CMP_WIDTH-1:0] sample_ext;
   logic signed [CMP_WIDTH-1:0] thresh_ext;
   logic signed [CMP_WIDTH-1:0] thresh_neg;
   logic [1:0]                  code;
   logic [SAMPLE_WIDTH-1:0]     mag;
   logic [2*SAMPLE_WIDTH-1:0]   sq_full;
   logic [SUM_WIDTH:0]          sum_wide;

   assign accept    = req_valid && !req_stall;
   assign stat_open = (count_ff < CNT_WIDTH'(STAT_LIMIT));

   // Classification against the current threshold.
   assign sample_ext = CMP_WIDTH'(req_sample_value);
   assign thresh_ext = signed'({{(CMP_WIDTH - THRESH_WIDTH){1'b0}}, threshold_ff});
   assign thresh_neg = -thresh_ext;

   always_comb begin
      if (sample_ext > thresh_ext) begin
         code = CODE_ABOVE;
      end else if (sample_ext < thresh_neg) begin
         code = CODE_BELOW;
      end else if (!req_sample_value[SAMPLE_WIDTH-1] && (req_sample_value != '0)) begin
         code = CODE_POS;
      end else begin
         code = CODE_NONPOS;
      end
   end

   assign queue_push      = accept;
   assign queue_data.code = code;
   assign queue_data.eop  = req_end_of_packet;

   // The square is registered; the sum takes it in the next cycle.
   assign mag      = req_sample_value[SAMPLE_WIDTH-1] ? unsigned'(-req_sample_value)
                                                       : unsigned'(req_sample_value);
   assign sq_full  = (2 * SAMPLE_WIDTH)'(mag) * (2 * SAMPLE_WIDTH)'(mag);
   assign sum_wide = {1'b0, sum_ff} + (SUM_WIDTH + 1)'(sq_ff);

   always_comb begin
      count_in    = count_ff;
      sq_valid_in = accept && stat_open;
      sum_in      = sum_ff;
      if (accept && stat_open) begin
         count_in = count_ff + 1'b1;
      end
      if (sq_valid_ff) begin
         sum_in = sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
      end
   end

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_write_enable) begin
         threshold_in = csr_write_data;
      end else if (rms_done) begin
         threshold_in = rms_threshold;
      end
   end

   // Next state. A packet end holds off new samples until the threshold
   // has been recomputed from the statistics, which stop at STAT_LIMIT.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FE_RUN: begin
            if (accept && req_end_of_packet) begin
               state_in = FE_SETTLE;
            end
         end
         FE_SETTLE: state_in = FE_LAUNCH;
         FE_LAUNCH: begin
            if (count_ff == '0) begin
               state_in = FE_RUN;
            end else begin
               state_in = FE_WAIT;
            end
         end
         FE_WAIT: begin
            if (rms_done) begin
               state_in = FE_RUN;
            end
         end
         default: state_in = FE_RUN;
      endcase
   end

   // Outputs.
   always_comb begin
      req_stall = (state_ff != FE_RUN) || queue_full;
      rms_start = (state_ff == FE_LAUNCH) && (count_ff != '0);
      rms_sum   = sum_ff;
      rms_count = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FE_RUN;
         threshold_ff <= THRESH_RESET;
         count_ff     <= '0;
         sum_ff       <= '0;
         sq_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         threshold_ff <= threshold_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sq_valid_ff  <= sq_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_full[SQ_WIDTH-1:0];
   end

endmodule

`default_nettype wire

/* hdl/tbaq_pack.sv */
`default_nettype none

module tbaq_pack (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tbaq_pkg::tbaq_entry_type head,
   input  wire logic                     empty,
   output      logic                     pop,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [7:0]               rsp_packed_byte,
   output      logic                     rsp_last_of_packet
);
   import tbaq_pkg::*;

   logic [1:0] pos_ff, pos_in;
   logic [7:0] partial_ff, partial_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [7:0] merged;
   logic       emits;
   logic       out_free;

   assign rsp_valid          = valid_ff;
   assign rsp_packed_byte    = byte_ff;
   assign rsp_last_of_packet = last_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         merged[2*i +: 2] = (pos_ff == 2'(i)) ? head.code : partial_ff[2*i +: 2];
      end
   end

   assign emits    = (pos_ff == LAST_SLOT) || head.eop;
   assign out_free = !valid_ff || !rsp_stall;
   // A code that does not close a byte is taken even while the output waits.
   assign pop      = !empty && (!emits || out_free);

   always_comb begin
      pos_in     = pos_ff;
      partial_in = partial_ff;
      valid_in   = valid_ff && rsp_stall;
      byte_in    = byte_ff;
      last_in    = last_ff;
      if (pop) begin
         if (emits) begin
            pos_in     = '0;
            partial_in = '0;
            valid_in   = 1'b1;
            byte_in    = merged;
            last_in    = head.eop;
         end else begin
            pos_in     = pos_ff + 1'b1;
            partial_in = merged;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         partial_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         partial_ff <= partial_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

/* hdl/two_bit_adaptive_quantizer_core.sv */
`default_nettype none

// Two-bit adaptive quantizer. Each signed Q3.12 sample becomes a two-bit code
// against the current threshold T (3 above T, 0 below -T, 2 positive, 1
// negative or zero); codes pack four to a byte, first sample in bits 1:0, and
// a packet end flushes a partial byte with zero fill and marks it last. Within
// a packet one sample is taken per clock while the queue has room. After a
// sample with end_of_packet the input stalls while the new threshold
// floor(sqrt(sum / count)) is formed by the bit-serial divider and square
// root that share one unit. Statistics stop accumulating after STAT_LIMIT
// samples. Writing the threshold register loads the threshold at once; write
// it only while the block is idle. Bytes wait in an output register and a
// four-entry queue lets classification run ahead of a stalled output.
module two_bit_adaptive_quantizer_core #(
   parameter int SAMPLE_WIDTH = tbaq_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int STAT_LIMIT   = tbaq_pkg::STAT_LIMIT_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0]       req_sample_value,
   input  wire logic                                 req_end_of_packet,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic [7:0]                           rsp_packed_byte,
   output      logic                                 rsp_last_of_packet,
   input  wire logic                                 csr_write_enable,
   input  wire logic [tbaq_pkg::THRESH_WIDTH-1:0]    csr_write_data
);
   import tbaq_pkg::*;

   localparam int CNT_WIDTH = $clog2(STAT_LIMIT + 1);

   tbaq_entry_type          queue_data;
   tbaq_entry_type          queue_head;
   logic                    queue_push;
   logic                    queue_pop;
   logic                    queue_empty;
   logic                    queue_full;
   logic                    rms_start;
   logic                    rms_done;
   logic [SUM_WIDTH-1:0]    rms_sum;
   logic [CNT_WIDTH-1:0]    rms_count;
   logic [THRESH_WIDTH-1:0] rms_threshold;

   tbaq_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .STAT_LIMIT   (STAT_LIMIT)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_value  (req_sample_value),
      .req_end_of_packet (req_end_of_packet),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .queue_full        (queue_full),
      .queue_push        (queue_push),
      .queue_data        (queue_data),
      .rms_start         (rms_start),
      .rms_sum           (rms_sum),
      .rms_count         (rms_count),
      .rms_done          (rms_done),
      .rms_threshold     (rms_threshold)
   );

   tbaq_rms #(
      .STAT_LIMIT (STAT_LIMIT)
   ) u_rms (
      .clock     (clock),
      .reset     (reset),
      .start     (rms_start),
      .sum       (rms_sum),
      .count     (rms_count),
      .done      (rms_done),
      .threshold (rms_threshold)
   );

   tbaq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_data),
      .pop       (queue_pop),
      .head      (queue_head),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   tbaq_pack u_pack (
      .clock              (clock),
      .reset              (reset),
      .head               (queue_head),
      .empty              (queue_empty),
      .pop                (queue_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_packed_byte    (rsp_packed_byte),
      .rsp_last_of_packet (rsp_last_of_packet)
   );

endmodule

`default_nettype wire
